>>> hdl/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg: shared types and constants of the chained hash table engine
// Payload structs, operation and status codes, controller/datapath command
// and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package chte_pkg;

  localparam int unsigned MAX_BUCKETS_LOG2 = 10;
  localparam int unsigned MIN_BUCKETS_LOG2 = 4;
  localparam int unsigned MAX_ENTRIES      = 1024;
  localparam int unsigned ADDR_W           = 10;
  localparam int unsigned PTR_W            = 11;
  localparam int unsigned ENT_W            = 96;

  localparam logic [PTR_W-1:0] NIL_PTR   = 11'd1024;
  localparam logic [31:0]      HASH_MULT = 32'h9E3779B9;
  localparam logic [3:0]       LOG2_MIN  = 4'd4;
  localparam logic [3:0]       LOG2_MAX  = 4'd10;

  localparam logic [1:0] FN_LOOKUP = 2'd0;
  localparam logic [1:0] FN_ADD    = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key_hash;
    logic [31:0] key;
    logic [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value_out;
    logic [1:0]  status;
    logic [10:0] entry_count;
    logic [3:0]  bucket_log2_out;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CFG, OP_CLR, OP_ACCEPT, OP_HEAD_RD, OP_HEAD_CAP, OP_ENT_RD, OP_CMP,
    OP_MTF1, OP_MTF2, OP_UPD_VAL, OP_RM1, OP_RM2, OP_RA_INIT, OP_RA_HEAD, OP_RA_HCAP,
    OP_RA_WALK, OP_RA_NCAP, OP_RB_START, OP_RB_CLR, OP_RC_SRD, OP_RC_SCAP, OP_RC_ERD,
    OP_RC_MUL, OP_ADD, OP_ADD_CAP, OP_APP_RD, OP_APP_WR, OP_APP_NIL, OP_APP_NIL_INC,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       hit;
    logic [1:0] status;
    logic       vsel;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       cur_nil;
    logic       prev_nil;
    logic       match;
    logic       free_nil;
    logic       grow_need;
    logic       at_max;
    logic       shrink_need;
    logic       scan_done;
    logic       clr_last;
    logic       cnt_done;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/chte_ram.sv
// ----------------------------------------------------------------------------
// chte_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module chte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hdl/chte_dp.sv
// ----------------------------------------------------------------------------
// chte_dp: datapath of the chained hash table engine
// Table memories, pointer registers, counters and the bucket hash unit.
// ----------------------------------------------------------------------------
`default_nettype none

module chte_dp
  import chte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ctl_cmd_t  cmd,
  input  wire in_item_t  in_item,
  input  wire logic [3:0] cfg_data,
  output dp_stat_t       stat,
  output out_item_t      out_item
);

  in_item_t           req_r;
  logic [31:0]        prod_r;
  logic [3:0]         log2_r;
  logic [3:0]         new_log2_r;
  logic [PTR_W-1:0]   live_r;
  logic [PTR_W-1:0]   free_r;
  logic [PTR_W-1:0]   head_r;
  logic [PTR_W-1:0]   cur_r;
  logic [PTR_W-1:0]   prev_r;
  logic [PTR_W-1:0]   curnext_r;
  logic [31:0]        vout_r;
  logic [ADDR_W-1:0]  clr_r;
  logic [PTR_W-1:0]   scan_r;
  logic [PTR_W-1:0]   cnt_r;
  logic [PTR_W-1:0]   j_r;
  out_item_t          out_r;

  logic [PTR_W-1:0]   n_w;
  logic [ADDR_W-1:0]  bkt;
  logic [31:0]        mul_a;
  logic [31:0]        mul_p;
  logic [3:0]         cfg_clamped;

  // memory ports
  logic               hd_we, tl_we, nx_we, en_we, sc_we;
  logic [ADDR_W-1:0]  hd_wa, tl_wa, nx_wa, en_wa, sc_wa;
  logic [PTR_W-1:0]   hd_wd, tl_wd, nx_wd;
  logic [ENT_W-1:0]   en_wd;
  logic [ADDR_W-1:0]  sc_wd;
  logic [ADDR_W-1:0]  hd_ra, nx_ra;
  logic [PTR_W-1:0]   hd_rd, tl_rd, nx_rd;
  logic [ENT_W-1:0]   en_rd;
  logic [ADDR_W-1:0]  sc_rd;
  logic [31:0]        en_hash, en_key, en_val;

  assign n_w     = PTR_W'(1) << log2_r;
  assign bkt     = ADDR_W'(prod_r >> (6'd32 - {2'b00, log2_r}));
  assign en_hash = en_rd[95:64];
  assign en_key  = en_rd[63:32];
  assign en_val  = en_rd[31:0];

  always_comb begin
    if (cfg_data < LOG2_MIN) begin
      cfg_clamped = LOG2_MIN;
    end else if (cfg_data > LOG2_MAX) begin
      cfg_clamped = LOG2_MAX;
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  // one shared multiplier for request and rehash buckets
  always_comb begin
    case (cmd.op)
      OP_ACCEPT: mul_a = in_item.key_hash;
      OP_RC_MUL: mul_a = en_hash;
      default:   mul_a = req_r.key_hash;
    endcase
  end
  assign mul_p = 32'(mul_a * HASH_MULT);

  assign stat.func        = req_r.func;
  assign stat.cur_nil     = cur_r[ADDR_W];
  assign stat.prev_nil    = prev_r[ADDR_W];
  assign stat.match       = (en_hash == req_r.key_hash) && (en_key == req_r.key);
  assign stat.free_nil    = free_r[ADDR_W];
  assign stat.grow_need   = live_r >= (n_w - (n_w >> 3));
  assign stat.at_max      = log2_r >= LOG2_MAX;
  assign stat.shrink_need = (log2_r > LOG2_MIN) && (live_r < (n_w >> 2));
  assign stat.scan_done   = scan_r == n_w;
  assign stat.clr_last    = &clr_r;
  assign stat.cnt_done    = j_r == cnt_r;
  assign out_item         = out_r;

  always_comb begin
    hd_we = 1'b0; hd_wa = bkt; hd_wd = cur_r;
    tl_we = 1'b0; tl_wa = bkt; tl_wd = cur_r;
    nx_we = 1'b0; nx_wa = cur_r[ADDR_W-1:0]; nx_wd = NIL_PTR;
    en_we = 1'b0; en_wa = cur_r[ADDR_W-1:0];
    en_wd = {req_r.key_hash, req_r.key, req_r.value_in};
    sc_we = 1'b0; sc_wa = cnt_r[ADDR_W-1:0]; sc_wd = cur_r[ADDR_W-1:0];
    hd_ra = (cmd.op == OP_RA_HEAD) ? scan_r[ADDR_W-1:0] : bkt;
    nx_ra = (cmd.op == OP_ADD) ? free_r[ADDR_W-1:0] : cur_r[ADDR_W-1:0];
    case (cmd.op)
      OP_CLR: begin
        hd_we = 1'b1; hd_wa = clr_r; hd_wd = NIL_PTR;
        nx_we = 1'b1; nx_wa = clr_r; nx_wd = {1'b0, clr_r} + PTR_W'(1);
      end
      OP_RB_CLR: begin
        hd_we = 1'b1; hd_wa = clr_r; hd_wd = NIL_PTR;
      end
      OP_MTF1: begin
        nx_we = 1'b1; nx_wa = prev_r[ADDR_W-1:0]; nx_wd = curnext_r;
        // moved entry was the tail: its predecessor becomes the tail
        tl_we = curnext_r[ADDR_W]; tl_wd = prev_r;
      end
      OP_MTF2: begin
        nx_we = 1'b1; nx_wd = head_r;
        hd_we = 1'b1;
      end
      OP_UPD_VAL: en_we = 1'b1;
      OP_RM1: begin
        hd_we = 1'b1; hd_wd = curnext_r;
      end
      OP_RM2: begin
        nx_we = 1'b1; nx_wd = free_r;
      end
      OP_RA_WALK: sc_we = 1'b1;
      OP_ADD: begin
        en_we = 1'b1; en_wa = free_r[ADDR_W-1:0];
      end
      OP_APP_WR: begin
        hd_we = hd_rd[ADDR_W];
        nx_we = !hd_rd[ADDR_W]; nx_wa = tl_rd[ADDR_W-1:0]; nx_wd = cur_r;
        tl_we = 1'b1;
      end
      OP_APP_NIL, OP_APP_NIL_INC: nx_we = 1'b1;
      default: ;
    endcase
  end

  chte_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ENTRIES)) u_heads (
    .clk(clk), .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
    .rd_addr(hd_ra), .rd_data(hd_rd)
  );
  chte_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ENTRIES)) u_tails (
    .clk(clk), .wr_en(tl_we), .wr_addr(tl_wa), .wr_data(tl_wd),
    .rd_addr(bkt), .rd_data(tl_rd)
  );
  chte_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ENTRIES)) u_next (
    .clk(clk), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
    .rd_addr(nx_ra), .rd_data(nx_rd)
  );
  chte_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_entry (
    .clk(clk), .wr_en(en_we), .wr_addr(en_wa), .wr_data(en_wd),
    .rd_addr(cur_r[ADDR_W-1:0]), .rd_data(en_rd)
  );
  chte_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ENTRIES)) u_scratch (
    .clk(clk), .wr_en(sc_we), .wr_addr(sc_wa), .wr_data(sc_wd),
    .rd_addr(j_r[ADDR_W-1:0]), .rd_data(sc_rd)
  );

  // table control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_r <= LOG2_MIN;
      live_r <= '0;
      free_r <= '0;
      clr_r  <= '0;
    end else begin
      case (cmd.op)
        OP_CFG: begin
          log2_r <= cfg_clamped;
          live_r <= '0;
          free_r <= '0;
          clr_r  <= '0;
        end
        OP_CLR, OP_RB_CLR: clr_r <= clr_r + ADDR_W'(1);
        OP_RM2: begin
          free_r <= cur_r;
          if (live_r != '0) begin
            live_r <= live_r - PTR_W'(1);
          end
        end
        OP_RB_START: begin
          log2_r <= new_log2_r;
          clr_r  <= '0;
        end
        OP_ADD_CAP:     free_r <= nx_rd;
        OP_APP_NIL_INC: live_r <= live_r + PTR_W'(1);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        req_r  <= in_item;
        prod_r <= mul_p;
      end
      OP_HEAD_CAP: begin
        head_r <= hd_rd;
        cur_r  <= hd_rd;
        prev_r <= NIL_PTR;
      end
      OP_CMP: begin
        curnext_r <= nx_rd;
        vout_r    <= en_val;
        if (!stat.match) begin
          prev_r <= cur_r;
          cur_r  <= nx_rd;
        end
      end
      OP_MTF2: curnext_r <= head_r;
      OP_RA_INIT: begin
        scan_r     <= '0;
        cnt_r      <= '0;
        new_log2_r <= (req_r.func == FN_ADD) ? log2_r + 4'd1 : log2_r - 4'd1;
      end
      OP_RA_HCAP: begin
        cur_r  <= hd_rd;
        scan_r <= scan_r + PTR_W'(1);
      end
      OP_RA_WALK: cnt_r <= cnt_r + PTR_W'(1);
      OP_RA_NCAP: cur_r <= nx_rd;
      OP_RB_CLR:  j_r   <= '0;
      OP_RC_SCAP: begin
        cur_r <= {1'b0, sc_rd};
        j_r   <= j_r + PTR_W'(1);
      end
      OP_RC_MUL: prod_r <= mul_p;
      OP_ADD: begin
        cur_r  <= free_r;
        prod_r <= mul_p;
      end
      OP_DONE: begin
        out_r.hit             <= cmd.hit;
        out_r.value_out       <= cmd.vsel ? vout_r : 32'd0;
        out_r.status          <= cmd.status;
        out_r.entry_count     <= live_r;
        out_r.bucket_log2_out <= log2_r;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/chte_ctrl.sv
// ----------------------------------------------------------------------------
// chte_ctrl: controller of the chained hash table engine
// Sequences chain walks, move-to-front, add/remove, rehash and clear passes.
// ----------------------------------------------------------------------------
`default_nettype none

module chte_ctrl
  import chte_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     cfg_valid,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd,
  output logic          busy,
  output logic          out_valid
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FHEAD, S_FHCAP, S_FRD, S_FCMP, S_MTF1, S_MTF2, S_HIT, S_RM2,
    S_SHR, S_MISS, S_RA_INIT, S_RA_HEAD, S_RA_HCAP, S_RA_WALK, S_RA_NCAP, S_RB_START,
    S_RB_CLR, S_RC_CHK, S_RC_SCAP, S_RC_ERD, S_RC_MUL, S_ADD, S_ADD_CAP, S_APP_RD,
    S_APP_WR, S_APP_NIL, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic       hit_r, hit_nxt;
  logic [1:0] st_r, st_nxt;
  logic       vsel_r, vsel_nxt;
  logic       reh_r, reh_nxt;
  logic       out_valid_r, out_valid_nxt;
  op_t        op;

  assign busy       = state_r != S_IDLE;
  assign out_valid  = out_valid_r;
  assign cmd.op     = op;
  assign cmd.hit    = hit_r;
  assign cmd.status = st_r;
  assign cmd.vsel   = vsel_r;

  always_comb begin
    state_nxt     = state_r;
    hit_nxt       = hit_r;
    st_nxt        = st_r;
    vsel_nxt      = vsel_r;
    reh_nxt       = reh_r;
    out_valid_nxt = 1'b0;
    op            = OP_NONE;
    if (cfg_valid) begin
      op        = OP_CFG;
      reh_nxt   = 1'b0;
      state_nxt = S_CLEAR;
    end else begin
      case (state_r)
        S_CLEAR: begin
          op = OP_CLR;
          if (stat.clr_last) state_nxt = S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op        = OP_ACCEPT;
            hit_nxt   = 1'b0;
            st_nxt    = ST_OK;
            vsel_nxt  = 1'b0;
            state_nxt = S_FHEAD;
          end
        end
        S_FHEAD: begin
          if (stat.func inside {FN_LOOKUP, FN_ADD, FN_REMOVE}) begin
            op        = OP_HEAD_RD;
            state_nxt = S_FHCAP;
          end else begin
            state_nxt = S_DONE;
          end
        end
        S_FHCAP: begin
          op        = OP_HEAD_CAP;
          state_nxt = S_FRD;
        end
        S_FRD: begin
          if (stat.cur_nil) begin
            state_nxt = S_MISS;
          end else begin
            op        = OP_ENT_RD;
            state_nxt = S_FCMP;
          end
        end
        S_FCMP: begin
          op = OP_CMP;
          if (!stat.match)        state_nxt = S_FRD;
          else if (stat.prev_nil) state_nxt = S_HIT;
          else                    state_nxt = S_MTF1;
        end
        S_MTF1: begin
          op        = OP_MTF1;
          state_nxt = S_MTF2;
        end
        S_MTF2: begin
          op        = OP_MTF2;
          state_nxt = S_HIT;
        end
        S_HIT: begin
          hit_nxt = 1'b1;
          case (stat.func)
            FN_LOOKUP: begin
              vsel_nxt  = 1'b1;
              state_nxt = S_DONE;
            end
            FN_ADD: begin
              op        = OP_UPD_VAL;
              state_nxt = S_DONE;
            end
            default: begin
              op        = OP_RM1;
              state_nxt = S_RM2;
            end
          endcase
        end
        S_RM2: begin
          op        = OP_RM2;
          state_nxt = S_SHR;
        end
        S_SHR: begin
          if (stat.shrink_need) begin
            reh_nxt   = 1'b1;
            state_nxt = S_RA_INIT;
          end else begin
            state_nxt = S_DONE;
          end
        end
        S_MISS: begin
          case (stat.func)
            FN_ADD: begin
              if (!stat.grow_need) begin
                state_nxt = S_ADD;
              end else if (stat.at_max) begin
                st_nxt    = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                reh_nxt   = 1'b1;
                state_nxt = S_RA_INIT;
              end
            end
            FN_REMOVE: begin
              st_nxt    = ST_NOTFOUND;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
        S_RA_INIT: begin
          op        = OP_RA_INIT;
          state_nxt = S_RA_HEAD;
        end
        S_RA_HEAD: begin
          if (stat.scan_done) begin
            state_nxt = S_RB_START;
          end else begin
            op        = OP_RA_HEAD;
            state_nxt = S_RA_HCAP;
          end
        end
        S_RA_HCAP: begin
          op        = OP_RA_HCAP;
          state_nxt = S_RA_WALK;
        end
        S_RA_WALK: begin
          if (stat.cur_nil) begin
            state_nxt = S_RA_HEAD;
          end else begin
            op        = OP_RA_WALK;
            state_nxt = S_RA_NCAP;
          end
        end
        S_RA_NCAP: begin
          op        = OP_RA_NCAP;
          state_nxt = S_RA_WALK;
        end
        S_RB_START: begin
          op        = OP_RB_START;
          state_nxt = S_RB_CLR;
        end
        S_RB_CLR: begin
          op = OP_RB_CLR;
          if (stat.clr_last) state_nxt = S_RC_CHK;
        end
        S_RC_CHK: begin
          if (stat.cnt_done) begin
            reh_nxt   = 1'b0;
            // a grow resumes the pending add, a shrink ends the remove
            state_nxt = (stat.func == FN_ADD) ? S_ADD : S_DONE;
          end else begin
            op        = OP_RC_SRD;
            state_nxt = S_RC_SCAP;
          end
        end
        S_RC_SCAP: begin
          op        = OP_RC_SCAP;
          state_nxt = S_RC_ERD;
        end
        S_RC_ERD: begin
          op        = OP_RC_ERD;
          state_nxt = S_RC_MUL;
        end
        S_RC_MUL: begin
          op        = OP_RC_MUL;
          state_nxt = S_APP_RD;
        end
        S_ADD: begin
          if (stat.free_nil) begin
            st_nxt    = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            op        = OP_ADD;
            state_nxt = S_ADD_CAP;
          end
        end
        S_ADD_CAP: begin
          op        = OP_ADD_CAP;
          state_nxt = S_APP_RD;
        end
        S_APP_RD: begin
          op        = OP_APP_RD;
          state_nxt = S_APP_WR;
        end
        S_APP_WR: begin
          op        = OP_APP_WR;
          state_nxt = S_APP_NIL;
        end
        S_APP_NIL: begin
          if (reh_r) begin
            op        = OP_APP_NIL;
            state_nxt = S_RC_CHK;
          end else begin
            op        = OP_APP_NIL_INC;
            state_nxt = S_DONE;
          end
        end
        S_DONE: begin
          op            = OP_DONE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      hit_r       <= 1'b0;
      st_r        <= ST_OK;
      vsel_r      <= 1'b0;
      reh_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hit_r       <= hit_nxt;
      st_r        <= st_nxt;
      vsel_r      <= vsel_nxt;
      reh_r       <= reh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/chained_hash_table_engine_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit: chained hash table with lookup/add/remove
// Top level joining the sequencing controller and the table datapath.
// ----------------------------------------------------------------------------
// One request is served at a time: start is taken when busy is low and
// cfg_valid is low, and the result is shown for exactly one cycle with
// out_valid; the receiver cannot stall it. A request walks its bucket's chain
// one entry at a time (each step is one registered read of the entry and
// next-pointer memories), with extra steps for move-to-front, remove or append.
// A resize rehash walks all old buckets and their entries, clears the
// 1024-entry bucket-head memory and re-links each entry. After reset and after
// every cfg write the block runs a clearing pass over the head and next-pointer
// memories with busy high; cfg writes are taken at any time and restart that
// pass.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_table_engine_unit
  import chte_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  output out_item_t       out_item,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  chte_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .cfg_valid(cfg_valid),
    .stat(stat), .cmd(cmd), .busy(busy), .out_valid(out_valid)
  );

  chte_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_item),
    .cfg_data(cfg_data), .stat(stat), .out_item(out_item)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !cfg_valid |=> busy)
    else $error("busy low right after a request was taken");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.entry_count <= 11'd1024 &&
                  out_item.bucket_log2_out >= LOG2_MIN &&
                  out_item.bucket_log2_out <= LOG2_MAX)
    else $error("entry count or bucket size out of range");
`endif

endmodule

`default_nettype wire
